@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property outside reset (active-low reset)
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

`endif

@@ hw/rtl/kis_pkg.sv @@
// Shared types and constants of the knot interval search block
package kis_pkg;

    // Fixed field widths
    localparam int TIME_W     = 32;
    localparam int ENTRY_W    = 8;
    localparam int KIDX_W     = 8;
    localparam int CNT_W      = 9;
    // Working index width: holds counts up to 256 plus a probe offset
    localparam int IDX_W      = 10;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register word indexes
    localparam logic REG_KNOT_COUNT = 1'b0;

    // Input word commands
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

endpackage

@@ hw/rtl/kis_knot_ram.sv @@
// Knot time table: one write port, one registered read port
module kis_knot_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [kis_pkg::TIME_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [kis_pkg::TIME_W-1:0] rd_data
);
    import kis_pkg::*;

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    // Store one knot time
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read of the addressed entry, enabled by rd_en
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/kis_apb_regs.sv @@
// Configuration register bank behind the APB-style port
module kis_apb_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kis_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kis_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kis_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [kis_pkg::CNT_W-1:0]      knot_count
);
    import kis_pkg::*;

    logic             wr_hit;
    logic             reg_sel;
    logic [CNT_W-1:0] knot_count_reg;

    // Word index from the byte address
    assign reg_sel = paddr[2];
    assign wr_hit  = psel && penable && pwrite && (reg_sel == REG_KNOT_COUNT);

    // Hold the knot count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knot_count_reg <= '0;
        end else if (wr_hit) begin
            knot_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Return the addressed register, zero elsewhere
    always_comb begin
        prdata = '0;
        if (reg_sel == REG_KNOT_COUNT) begin
            prdata = APB_DATA_W'(knot_count_reg);
        end
    end

    assign pready     = 1'b1;
    assign knot_count = knot_count_reg;

endmodule

@@ hw/rtl/kis_search_ctrl.sv @@
// Search sequencer: halving probes and linear finish over the knot table
module kis_search_ctrl #(
    parameter int MAX_KNOTS = 256,
    parameter int AW        = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [kis_pkg::CNT_W-1:0]    knot_count,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [kis_pkg::ENTRY_W-1:0]  s_entry_index,
    input  logic [kis_pkg::TIME_W-1:0]   s_time_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [kis_pkg::KIDX_W-1:0]   m_knot_index,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output logic [kis_pkg::TIME_W-1:0]   wr_data,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    input  logic [kis_pkg::TIME_W-1:0]   rd_data
);
    import kis_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_CMP1,
        ST_CMP2,
        ST_SCAN,
        ST_SCMP,
        ST_FIN
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [TIME_W-1:0] t_reg, t_next;
    logic [IDX_W-1:0]         n_reg, n_next;
    logic [IDX_W-1:0]         base_reg, base_next;
    logic [IDX_W-1:0]         half_reg, half_next;
    logic                     even_reg, even_next;
    logic                     rd_oor_reg, rd_oor_next;
    logic                     m_valid_reg, m_valid_next;
    logic [KIDX_W-1:0]        m_idx_reg, m_idx_next;

    logic [IDX_W-1:0]         n_eff;
    logic [IDX_W-1:0]         probe_idx;
    logic [IDX_W-1:0]         plus1_idx;
    logic [IDX_W-1:0]         result_idx;
    logic [IDX_W-1:0]         rd_idx;
    logic signed [TIME_W-1:0] probe_val;
    logic                     slot_ok;

    // Clamp the count to the table depth
    assign n_eff = (32'(knot_count) > MAX_KNOTS) ? IDX_W'(MAX_KNOTS) : IDX_W'(knot_count);

    assign probe_idx = base_reg + half_reg;
    assign plus1_idx = probe_idx + IDX_W'(1);

    // Entries beyond the table read as zero
    assign probe_val = rd_oor_reg ? '0 : $signed(rd_data);

    // Step back from one past the end onto the last knot
    assign result_idx = (base_reg == n_reg && base_reg != '0) ? base_reg - IDX_W'(1) : base_reg;

    assign slot_ok = (32'(s_entry_index) < MAX_KNOTS);

    // Table write port follows the input word
    assign wr_addr = AW'(s_entry_index);
    assign wr_data = s_time_value;
    assign rd_addr = AW'(rd_idx);

    // Next-state logic
    always_comb begin
        state_next   = state_reg;
        t_next       = t_reg;
        n_next       = n_reg;
        base_next    = base_reg;
        half_next    = half_reg;
        even_next    = even_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_idx_next   = m_idx_reg;
        s_ready      = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_idx       = base_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == CMD_SEARCH) begin
                        t_next     = $signed(s_time_value);
                        n_next     = n_eff;
                        base_next  = '0;
                        half_next  = n_eff;
                        state_next = ST_LOOP;
                    end else begin
                        wr_en = slot_ok;
                    end
                end
            end
            ST_LOOP: begin
                // Halve the window and probe its midpoint
                if (half_reg > IDX_W'(1)) begin
                    half_next  = half_reg >> 1;
                    even_next  = !half_reg[0];
                    rd_en      = 1'b1;
                    rd_idx     = base_reg + (half_reg >> 1);
                    state_next = ST_CMP1;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_CMP1: begin
                if (even_reg) begin
                    if (t_reg >= probe_val) begin
                        if (plus1_idx >= n_reg) begin
                            base_next  = probe_idx;
                            state_next = ST_SCAN;
                        end else begin
                            rd_en      = 1'b1;
                            rd_idx     = plus1_idx;
                            state_next = ST_CMP2;
                        end
                    end else begin
                        state_next = ST_LOOP;
                    end
                end else begin
                    if (t_reg >= probe_val) begin
                        base_next = probe_idx;
                    end
                    half_next  = half_reg + IDX_W'(1);
                    state_next = ST_LOOP;
                end
            end
            ST_CMP2: begin
                // Neighbour probe: stop if the query falls before it
                if (t_reg < probe_val) begin
                    base_next  = probe_idx;
                    state_next = ST_SCAN;
                end else begin
                    base_next  = plus1_idx;
                    half_next  = half_reg - IDX_W'(1);
                    state_next = ST_LOOP;
                end
            end
            ST_SCAN: begin
                if (base_reg < n_reg) begin
                    rd_en      = 1'b1;
                    rd_idx     = base_reg;
                    state_next = ST_SCMP;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SCMP: begin
                if (probe_val > t_reg) begin
                    state_next = ST_FIN;
                end else begin
                    base_next  = base_reg + IDX_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = result_idx[KIDX_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Flag reads beyond the table
    always_comb begin
        rd_oor_next = rd_oor_reg;
        if (rd_en) begin
            rd_oor_next = (32'(rd_idx) >= MAX_KNOTS);
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        t_reg      <= t_next;
        n_reg      <= n_next;
        base_reg   <= base_next;
        half_reg   <= half_next;
        even_reg   <= even_next;
        rd_oor_reg <= rd_oor_next;
        m_idx_reg  <= m_idx_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_knot_index = m_idx_reg;

endmodule

@@ hw/rtl/knot_interval_search.sv @@
// Knot interval search: top level joining register bank, sequencer and knot table
// A write word is taken while idle and gives no result.
// A search runs halving probes (about log2 of the knot count of them) and
// then linear finish steps; each probe and step waits on the single read port
// of the knot table. One search in flight. Reset clears the knot count, the
// sequencer and the result valid; the table contents are undefined until written.
module knot_interval_search #(
    parameter int MAX_KNOTS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kis_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kis_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kis_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [kis_pkg::ENTRY_W-1:0]    s_entry_index,
    input  logic [kis_pkg::TIME_W-1:0]     s_time_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [kis_pkg::KIDX_W-1:0]     m_knot_index
);
    import kis_pkg::*;

    localparam int AW = $clog2(MAX_KNOTS);

    logic [CNT_W-1:0]  knot_count;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [TIME_W-1:0] rd_data;

    // Configuration registers
    kis_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .knot_count (knot_count)
    );

    // Search sequencer
    kis_search_ctrl #(
        .MAX_KNOTS (MAX_KNOTS),
        .AW        (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .knot_count    (knot_count),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_entry_index (s_entry_index),
        .s_time_value  (s_time_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_knot_index  (m_knot_index),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // Knot time table
    kis_knot_ram #(
        .DEPTH (MAX_KNOTS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

@@ hw/rtl/kis_checker.sv @@
// Port-level checks for the knot interval search, bound to the top level
`include "assert_macros.svh"

module kis_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_command,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_knot_index,
    input logic [31:0] prdata
);

    // No result straight out of reset
    `ASSERT_ALWAYS(a_reset_no_result, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result holds its word
    `ASSERT_RST(a_result_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_knot_index), "stalled result changed")

    // A table write produces no result
    `ASSERT_RST(a_write_silent, aclk, aresetn, s_valid && s_ready && !s_command && !m_valid |=> !m_valid, "result after table write")

    // A search holds off the next word
    `ASSERT_RST(a_search_busy, aclk, aresetn, s_valid && s_ready && s_command |=> !s_ready, "input taken during search")

    // Register reads carry only the count bits
    `ASSERT_RST(a_prdata_range, aclk, aresetn, prdata[31:9] == 23'd0, "register read out of range")

endmodule

bind knot_interval_search kis_checker u_kis_checker (.*);
